/* src/hbs_pkg.sv */
// Shared constants and types for the height map smoothing block.
package hbs_pkg;

    localparam int MAP_DIM   = 64;
    localparam int COORD_W   = $clog2(MAP_DIM);
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int H_W       = 24;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 15;
    localparam int PASS_W    = 3;
    localparam int VERT_W    = 9;

    localparam logic [GAIN_W-1:0] GAIN_ONE   = 16'd32768;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd24576;
    localparam logic [PASS_W-1:0] PASS_RESET = 3'd3;

    localparam logic [VERT_W-1:0] VERT_STEP = 9'd5;
    localparam logic [VERT_W-1:0] VERT_BASE = 9'd200;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic REPLY_DONE = 1'b0;
    localparam logic REPLY_READ = 1'b1;

    localparam logic CFG_GAIN   = 1'b0;
    localparam logic CFG_PASSES = 1'b1;

    typedef struct packed {
        logic load_diff;
        logic load_prod;
    } t_blend_ctrl;

endpackage

/* src/heightmap_bidirectional_smoothing.sv */
// Top level: height map store, smoothing sequencer and reply register.
// A write beat writes the map on acceptance; a read out state loads a read reply.
// A run beat walks 4*(MAP_DIM-1)*MAP_DIM cells per pass, each in four steps (read,
// difference, multiply, write back), then a done state loads its reply.
// A reply that finds the reply register full waits, and the input stays not ready.
// Reset clears state and output valid, presets gain and passes; the map stays undefined.
module heightmap_bidirectional_smoothing (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // Fields from bit 0: col[5:0], row[11:6], height_in[35:12], zero fill.
    input  logic [39:0]                  i_s_tdata,
    // Fields from bit 0: op[1:0].
    input  logic [1:0]                   i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // Fields from bit 0: height_out[23:0], vertex_x[32:24], vertex_z[41:33], zero fill.
    output logic [47:0]                  o_m_tdata,
    // Fields from bit 0: reply_kind[0].
    output logic [0:0]                   o_m_tuser,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [hbs_pkg::GAIN_W-1:0]   i_cfg_data
);
    import hbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_OUT,
        S_CELL_READ,
        S_CELL_DIFF,
        S_CELL_MUL,
        S_CELL_WRITE,
        S_DONE
    } t_state;

    t_state r_state;

    logic [GAIN_W-1:0]  r_gain;
    logic [PASS_W-1:0]  r_pass_count;
    logic [PASS_W-1:0]  r_pass_counter;
    logic [1:0]         r_phase;
    logic [COORD_W-1:0] r_sweep_a;
    logic [COORD_W-1:0] r_sweep_b;

    logic [COORD_W-1:0] r_rd_col;
    logic [COORD_W-1:0] r_rd_row;
    logic               r_rd_inside;

    logic               r_out_valid;
    logic               r_out_kind;
    logic [H_W-1:0]     r_out_height;
    logic [VERT_W-1:0]  r_out_vx;
    logic [VERT_W-1:0]  r_out_vz;

    logic [H_W-1:0]     r_mem [MAP_DIM*MAP_DIM];
    logic [H_W-1:0]     r_rd_a;
    logic [H_W-1:0]     r_rd_b;

    logic [1:0]         in_op;
    logic [COORD_W-1:0] in_col;
    logic [COORD_W-1:0] in_row;
    logic [H_W-1:0]     in_height;
    logic               in_inside;
    logic               s_accept;
    logic               out_free;

    logic [COORD_W-1:0] idx_own;
    logic [COORD_W-1:0] idx_nb;
    logic [ADDR_W-1:0]  own_addr;
    logic [ADDR_W-1:0]  nb_addr;
    logic [GAIN_W-1:0]  gain_sat;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [H_W-1:0]     mem_wdata;
    logic               rd_a_en;
    logic [ADDR_W-1:0]  rd_a_addr;
    logic               rd_b_en;

    t_blend_ctrl        blend_ctrl;
    logic signed [H_W-1:0] blend_result;

    logic last_b;
    logic last_a;
    logic last_phase;
    logic last_pass;

    assign in_op     = i_s_tuser;
    assign in_col    = i_s_tdata[5:0];
    assign in_row    = i_s_tdata[11:6];
    assign in_height = i_s_tdata[35:12];
    assign in_inside = (32'(in_col) < MAP_DIM) && (32'(in_row) < MAP_DIM);

    assign o_s_tready  = (r_state == S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {6'd0, r_out_vz, r_out_vx, r_out_height};

    always_comb begin
        gain_sat = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;
        idx_own  = r_phase[0] ? COORD_W'(MAP_DIM - 2) - r_sweep_a : r_sweep_a + COORD_W'(1);
        idx_nb   = r_phase[0] ? COORD_W'(MAP_DIM - 1) - r_sweep_a : r_sweep_a;
        own_addr = r_phase[1] ? {r_sweep_b, idx_own} : {idx_own, r_sweep_b};
        nb_addr  = r_phase[1] ? {r_sweep_b, idx_nb} : {idx_nb, r_sweep_b};

        last_b     = (r_sweep_b == COORD_W'(MAP_DIM - 1));
        last_a     = (r_sweep_a == COORD_W'(MAP_DIM - 2));
        last_phase = (r_phase == 2'd3);
        last_pass  = ((r_pass_counter + PASS_W'(1)) == r_pass_count);

        mem_we    = 1'b0;
        mem_waddr = own_addr;
        mem_wdata = blend_result;
        rd_a_en   = 1'b0;
        rd_a_addr = own_addr;
        rd_b_en   = 1'b0;

        if (s_accept && in_op == OP_WRITE && in_inside) begin
            mem_we    = 1'b1;
            mem_waddr = {in_col, in_row};
            mem_wdata = in_height;
        end else if (r_state == S_CELL_WRITE) begin
            mem_we = 1'b1;
        end

        if (s_accept && in_op == OP_READ) begin
            rd_a_en   = 1'b1;
            rd_a_addr = {in_col, in_row};
        end else if (r_state == S_CELL_READ) begin
            rd_a_en = 1'b1;
            rd_b_en = 1'b1;
        end

        blend_ctrl.load_diff = (r_state == S_CELL_DIFF);
        blend_ctrl.load_prod = (r_state == S_CELL_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_a_en) begin
            r_rd_a <= r_mem[rd_a_addr];
        end
        if (rd_b_en) begin
            r_rd_b <= r_mem[nb_addr];
        end
    end

    hbs_blend u_blend (
        .i_clk    (i_clk),
        .i_ctrl   (blend_ctrl),
        .i_own    (r_rd_a),
        .i_nb     (r_rd_b),
        .i_gain   (gain_sat),
        .o_result (blend_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_gain         <= GAIN_RESET;
            r_pass_count   <= PASS_RESET;
            r_pass_counter <= '0;
            r_phase        <= '0;
            r_sweep_a      <= '0;
            r_sweep_b      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_GAIN:   r_gain       <= i_cfg_data;
                    CFG_PASSES: r_pass_count <= i_cfg_data[PASS_W-1:0];
                endcase
            end

            if (r_out_valid && i_m_tready && r_state != S_READ_OUT && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        case (in_op)
                            OP_RUN: begin
                                r_state <= (r_pass_count == '0) ? S_DONE : S_CELL_READ;
                            end
                            OP_READ: begin
                                r_rd_col    <= in_col;
                                r_rd_row    <= in_row;
                                r_rd_inside <= in_inside;
                                r_state     <= S_READ_OUT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= REPLY_READ;
                        r_out_height <= r_rd_inside ? r_rd_a : '0;
                        r_out_vx     <= VERT_W'({3'd0, r_rd_col} * VERT_STEP) - VERT_BASE;
                        r_out_vz     <= VERT_W'({3'd0, r_rd_row} * VERT_STEP) - VERT_BASE;
                        r_state      <= S_IDLE;
                    end
                end
                S_CELL_READ: r_state <= S_CELL_DIFF;
                S_CELL_DIFF: r_state <= S_CELL_MUL;
                S_CELL_MUL:  r_state <= S_CELL_WRITE;
                S_CELL_WRITE: begin
                    r_state <= S_CELL_READ;
                    if (last_b) begin
                        r_sweep_b <= '0;
                        if (last_a) begin
                            r_sweep_a <= '0;
                            r_phase   <= r_phase + 2'd1;
                            if (last_phase) begin
                                if (last_pass) begin
                                    r_pass_counter <= '0;
                                    r_state        <= S_DONE;
                                end else begin
                                    r_pass_counter <= r_pass_counter + PASS_W'(1);
                                end
                            end
                        end else begin
                            r_sweep_a <= r_sweep_a + COORD_W'(1);
                        end
                    end else begin
                        r_sweep_b <= r_sweep_b + COORD_W'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= REPLY_DONE;
                        r_out_height <= '0;
                        r_out_vx     <= '0;
                        r_out_vz     <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_idle_walker_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            (r_pass_counter == '0 && r_phase == '0 && r_sweep_a == '0 && r_sweep_b == '0))
        else $error("Walker state not cleared while idle.");

    a_done_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == REPLY_DONE) |-> (o_m_tdata == '0))
        else $error("Run reply carries a nonzero payload.");

    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((s_accept && in_op == OP_WRITE) || r_state == S_CELL_WRITE))
        else $error("Map written outside a write beat or a cell write back.");

    a_sweep_ends_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL_WRITE && last_b && last_a && last_phase && last_pass)
            |=> (r_state == S_DONE))
        else $error("Final cell of a run did not lead to the reply.");

endmodule

/* src/hbs_blend.sv */
// Shared two-step blend unit: nb + floor((own - nb) * gain / 2^15).
module hbs_blend (
    input  logic                                i_clk,
    input  hbs_pkg::t_blend_ctrl                i_ctrl,
    input  logic signed [hbs_pkg::H_W-1:0]      i_own,
    input  logic signed [hbs_pkg::H_W-1:0]      i_nb,
    input  logic        [hbs_pkg::GAIN_W-1:0]   i_gain,
    output logic signed [hbs_pkg::H_W-1:0]      o_result
);
    import hbs_pkg::*;

    localparam int DIFF_W = H_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int SUM_W  = H_W + 3;

    logic signed [DIFF_W-1:0] r_diff;
    logic signed [H_W-1:0]    r_nb;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] prod_shift;
    logic signed [SUM_W-1:0]  sum;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_diff) begin
            r_diff <= {i_own[H_W-1], i_own} - {i_nb[H_W-1], i_nb};
            r_nb   <= i_nb;
        end
        if (i_ctrl.load_prod) begin
            r_prod <= r_diff * $signed({1'b0, i_gain});
        end
    end

    always_comb begin
        prod_shift = r_prod >>> GAIN_FRAC;
        sum        = {{(SUM_W-H_W){r_nb[H_W-1]}}, r_nb} + prod_shift[SUM_W-1:0];
        o_result   = sum[H_W-1:0];
    end

endmodule

/* test/testbench.sv */
// Self-checking testbench for the height map smoothing block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hbs_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [VERT_W-1:0] VERT_LOW  = -VERT_BASE;
    localparam logic [VERT_W-1:0] VERT_HIGH = VERT_W'(VERT_STEP * (MAP_DIM - 1) - VERT_BASE);
    localparam int DIR_ROW_COUNT = 17;

    typedef struct packed {
        logic                  kind;
        logic [H_W-1:0]        height;
        logic [VERT_W-1:0]     vx;
        logic [VERT_W-1:0]     vz;
    } t_reply;

    typedef struct packed {
        logic [1:0]            op;
        logic [COORD_W-1:0]    col;
        logic [COORD_W-1:0]    row;
        logic [H_W-1:0]        height;
        logic                  fixed;
        t_reply                reply;
    } t_row;

    localparam t_reply NO_REPLY = '0;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [39:0]         i_s_tdata = '0;
    logic [1:0]          i_s_tuser = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [47:0]         o_m_tdata;
    logic [0:0]          o_m_tuser;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = 1'b0;
    logic [GAIN_W-1:0]   i_cfg_data = '0;

    logic signed [H_W-1:0] height_map [MAP_DIM*MAP_DIM];
    logic [GAIN_W-1:0]     gain_reg = GAIN_RESET;
    logic [PASS_W-1:0]     passes_reg = PASS_RESET;
    t_reply                pending_replies [$];
    int                    mismatch_count = 0;
    logic [COORD_W-1:0]    last_col = '0;
    logic [COORD_W-1:0]    last_row = '0;
    int                    send_calm = 0;
    t_row                  dir_rows [DIR_ROW_COUNT];

    heightmap_bidirectional_smoothing i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(80_000_000);
        $display("tb: failure");
        $finish;
    end

    task automatic draw_gap(inout int calm, output int gap);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(8, 40);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 6);
        end
    endtask

    function automatic logic [H_W-1:0] blend_heights(input logic signed [H_W-1:0] nb,
                                                     input logic signed [H_W-1:0] own,
                                                     input int g);
        longint acc;
        acc = longint'(nb) * longint'(int'(GAIN_ONE) - g) + longint'(own) * longint'(g);
        return H_W'(acc >>> GAIN_FRAC);
    endfunction

    task automatic smooth_map();
        int g, i, j, own, nb;
        g = (gain_reg > GAIN_ONE) ? int'(GAIN_ONE) : int'(gain_reg);
        for (int p = 0; p < passes_reg; p++) begin
            for (int dir = 0; dir < 4; dir++) begin
                for (int a = 1; a < MAP_DIM; a++) begin
                    for (int b = 0; b < MAP_DIM; b++) begin
                        i = dir[0] ? (MAP_DIM - 1 - a) : a;
                        j = dir[0] ? (i + 1) : (i - 1);
                        if (dir < 2) begin
                            own = i * MAP_DIM + b;
                            nb  = j * MAP_DIM + b;
                        end else begin
                            own = b * MAP_DIM + i;
                            nb  = b * MAP_DIM + j;
                        end
                        height_map[own] = blend_heights(height_map[nb], height_map[own], g);
                    end
                end
            end
        end
    endtask

    task automatic predict_item(input logic [1:0] op, input logic [COORD_W-1:0] col,
                                input logic [COORD_W-1:0] row, input logic [H_W-1:0] h,
                                output bit has_reply, output t_reply rep);
        int addr;
        addr = int'(col) * MAP_DIM + int'(row);
        has_reply = 1'b0;
        rep = NO_REPLY;
        case (op)
            OP_WRITE: begin
                height_map[addr] = h;
            end
            OP_RUN: begin
                smooth_map();
                has_reply = 1'b1;
                rep.kind = REPLY_DONE;
            end
            OP_READ: begin
                has_reply = 1'b1;
                rep.kind = REPLY_READ;
                rep.height = height_map[addr];
                rep.vx = VERT_W'(int'(col) * int'(VERT_STEP) - int'(VERT_BASE));
                rep.vz = VERT_W'(int'(row) * int'(VERT_STEP) - int'(VERT_BASE));
            end
            default: begin
            end
        endcase
    endtask

    task automatic push_item(input logic [1:0] op, input logic [COORD_W-1:0] col,
                             input logic [COORD_W-1:0] row, input logic [H_W-1:0] h,
                             input bit fixed, input t_reply fixed_reply);
        int gap;
        bit has_reply;
        t_reply rep;
        draw_gap(send_calm, gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {4'b0, h, row, col};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        predict_item(op, col, row, h, has_reply, rep);
        if (has_reply) begin
            if (fixed)
                rep = fixed_reply;
            pending_replies.push_back(rep);
        end
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [GAIN_W-1:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_GAIN)
            gain_reg = val;
        else
            passes_reg = val[PASS_W-1:0];
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? COORD_W'(MAP_DIM - 1) : '0;
        return COORD_W'($urandom_range(0, MAP_DIM - 1));
    endfunction

    function automatic logic [H_W-1:0] pick_height();
        case ($urandom_range(0, 15))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return H_W'($urandom);
        endcase
    endfunction

    task automatic random_items(input int count, input bit heavy_run);
        int counted, r;
        logic [1:0] op;
        logic [COORD_W-1:0] col, row;
        counted = 0;
        while (counted < count) begin
            r = $urandom_range(0, 99);
            if (heavy_run && counted == count / 2)
                op = OP_RUN;
            else if (r < 40)
                op = OP_WRITE;
            else if (r < 85)
                op = OP_READ;
            else if (r < 95)
                op = (passes_reg == 0) ? OP_RUN : OP_READ;
            else
                op = OP_UNUSED;
            if ($urandom_range(0, 3) == 0) begin
                col = last_col;
                row = last_row;
            end else begin
                col = pick_coord();
                row = pick_coord();
            end
            push_item(op, col, row, pick_height(), 1'b0, NO_REPLY);
            if (op == OP_WRITE) begin
                last_col = col;
                last_row = row;
            end
            if (op != OP_UNUSED)
                counted++;
        end
    endtask

    initial begin : reply_side
        int gap, calm;
        t_reply got, want;
        calm = 0;
        forever begin
            draw_gap(calm, gap);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
            got.kind   = o_m_tuser[0];
            got.height = o_m_tdata[23:0];
            got.vx     = o_m_tdata[32:24];
            got.vz     = o_m_tdata[41:33];
            if (pending_replies.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected reply beat: expected none, actual %h", $realtime, got);
            end else begin
                want = pending_replies.pop_front();
                if (got.kind !== want.kind) begin
                    mismatch_count++;
                    $display("%0t: reply_kind mismatch: expected %h, actual %h",
                             $realtime, want.kind, got.kind);
                end
                if (got.height !== want.height) begin
                    mismatch_count++;
                    $display("%0t: height_out mismatch: expected %h, actual %h",
                             $realtime, want.height, got.height);
                end
                if (got.vx !== want.vx) begin
                    mismatch_count++;
                    $display("%0t: vertex_x mismatch: expected %h, actual %h",
                             $realtime, want.vx, got.vx);
                end
                if (got.vz !== want.vz) begin
                    mismatch_count++;
                    $display("%0t: vertex_z mismatch: expected %h, actual %h",
                             $realtime, want.vz, got.vz);
                end
            end
        end
    end

    initial begin : stimulus
        dir_rows = '{
            {OP_WRITE,  6'd0,  6'd0,  24'h7FFFFF, 1'b0, NO_REPLY},
            {OP_WRITE,  6'd63, 6'd63, 24'h800000, 1'b0, NO_REPLY},
            {OP_WRITE,  6'd63, 6'd0,  24'hFFFFFF, 1'b0, NO_REPLY},
            {OP_WRITE,  6'd0,  6'd63, 24'h000000, 1'b0, NO_REPLY},
            {OP_READ,   6'd0,  6'd0,  24'h000000, 1'b1,
                {REPLY_READ, 24'h7FFFFF, VERT_LOW, VERT_LOW}},
            {OP_READ,   6'd63, 6'd63, 24'hFFFFFF, 1'b1,
                {REPLY_READ, 24'h800000, VERT_HIGH, VERT_HIGH}},
            {OP_READ,   6'd63, 6'd0,  24'h555555, 1'b1,
                {REPLY_READ, 24'hFFFFFF, VERT_HIGH, VERT_LOW}},
            {OP_READ,   6'd0,  6'd63, 24'hAAAAAA, 1'b1,
                {REPLY_READ, 24'h000000, VERT_LOW, VERT_HIGH}},
            {OP_UNUSED, 6'd0,  6'd0,  24'h123456, 1'b0, NO_REPLY},
            {OP_READ,   6'd0,  6'd0,  24'h000000, 1'b1,
                {REPLY_READ, 24'h7FFFFF, VERT_LOW, VERT_LOW}},
            {OP_WRITE,  6'd0,  6'd0,  24'h000100, 1'b0, NO_REPLY},
            {OP_READ,   6'd0,  6'd0,  24'h000000, 1'b1,
                {REPLY_READ, 24'h000100, VERT_LOW, VERT_LOW}},
            {OP_WRITE,  6'd32, 6'd17, 24'h123456, 1'b0, NO_REPLY},
            {OP_READ,   6'd32, 6'd17, 24'h000000, 1'b0, NO_REPLY},
            {OP_WRITE,  6'd21, 6'd42, 24'hABCDEF, 1'b0, NO_REPLY},
            {OP_WRITE,  6'd21, 6'd42, 24'h000001, 1'b0, NO_REPLY},
            {OP_READ,   6'd21, 6'd42, 24'h000000, 1'b0, NO_REPLY}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROW_COUNT; k++)
            push_item(dir_rows[k].op, dir_rows[k].col, dir_rows[k].row,
                      dir_rows[k].height, dir_rows[k].fixed, dir_rows[k].reply);

        // A smoothing run may only start once every cell holds a known height.
        for (int c = 0; c < MAP_DIM; c++)
            for (int r = 0; r < MAP_DIM; r++)
                push_item(OP_WRITE, COORD_W'(c), COORD_W'(r), pick_height(), 1'b0, NO_REPLY);

        random_items(400, 1'b1);

        write_reg(CFG_GAIN, '0);
        write_reg(CFG_PASSES, {13'($urandom), 3'd1});
        random_items(300, 1'b1);

        write_reg(CFG_GAIN, GAIN_ONE);
        random_items(200, 1'b1);

        write_reg(CFG_GAIN, GAIN_W'($urandom_range(1, 32767)));
        write_reg(CFG_PASSES, {13'($urandom), 3'd0});
        random_items(400, 1'b0);

        write_reg(CFG_GAIN, GAIN_W'($urandom_range(1, 32767)));
        write_reg(CFG_PASSES, {13'($urandom), 3'd7});
        random_items(200, 1'b1);

        write_reg(CFG_GAIN, GAIN_W'($urandom_range(32769, 65535)));
        write_reg(CFG_PASSES, {13'($urandom), 3'd1});
        random_items(200, 1'b1);

        write_reg(CFG_PASSES, {13'($urandom), 3'd0});
        random_items(100, 1'b0);

        wait_idle();
        repeat (12) @(posedge i_clk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
